[sv/glrd_pkg.sv]
// Shared types, codes and scaling functions for the glove report deframer.
// No dependencies; every other file imports this package.
package glrd_pkg;

    // Longest report the byte store holds, and the shortest report length.
    localparam int FRAME_MAX   = 10;
    localparam int FRAME_MIN   = 9;
    localparam int TIMER_WIDTH = 24;

    localparam int COUNT_W = $clog2(FRAME_MAX + 1);
    localparam int IDX_W   = $clog2(FRAME_MAX);

    // Finger and attitude bytes sit at report positions 1 to 7.
    localparam int DATA_BYTES = 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [7:0] HEADER_BYTE = 8'h80;
    localparam logic [7:0] CAP_LEFT    = 8'h40;
    localparam logic [7:0] CAP_RIGHT   = 8'h01;

    localparam logic [3:0]  FRAME_LENGTH_RST  = 4'd9;
    localparam logic        WIRELESS_MODE_RST = 1'b0;
    localparam logic [23:0] TIMEOUT_TICKS_RST = 24'd2000000;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } glrd_cmd_t;

    typedef enum logic [1:0] {
        EV_REPORT     = 2'd0,
        EV_BAD_HEADER = 2'd1,
        EV_BAD_CAP    = 2'd2,
        EV_TIMEOUT    = 2'd3
    } glrd_event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_LENGTH  = 2'd0,
        REG_WIRELESS_MODE = 2'd1,
        REG_TIMEOUT_TICKS = 2'd2
    } glrd_reg_idx_t;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } glrd_in_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [15:0] thumb;
        logic [15:0] index_finger;
        logic [15:0] middle_finger;
        logic [15:0] ring_finger;
        logic [15:0] little_finger;
        logic [15:0] pitch;
        logic [15:0] roll;
        logic        right_hand;
    } glrd_out_t;

    typedef struct packed {
        logic [3:0]  frame_length;
        logic        wireless_mode;
        logic [23:0] timeout_ticks;
    } glrd_cfg_t;

    // Decoded event from the frame tracker; data_bytes[0] is report byte 1.
    typedef struct packed {
        logic                       valid;
        logic [1:0]                 kind;
        logic [DATA_BYTES-1:0][7:0] data_bytes;
        logic                       right_hand;
    } glrd_evt_t;

    // byte * 257: the byte repeated in both halves.
    function automatic logic [15:0] finger_scale(input logic [7:0] b);
        return {b, b};
    endfunction

    // (46080*b + 127) / 255 rewritten as 180*b + (180*b + 127) / 255.
    // The inner quotient: y = 256a + c = 255a + (a + c), and a + c < 510,
    // so one compare corrects the estimate a.
    function automatic logic [15:0] angle_scale(input logic [7:0] b);
        logic [15:0] prod;
        logic [15:0] y;
        logic [8:0]  rem;
        prod = 16'({8'd0, b} * 16'd180);
        y    = prod + 16'd127;
        rem  = {1'b0, y[15:8]} + {1'b0, y[7:0]};
        return prod + {8'd0, y[15:8]} + 16'(rem >= 9'd255);
    endfunction

endpackage

[sv/glrd_frame_track.sv]
// Header hunt, report gathering, checks and idle timer of the deframer.
// Depends on glrd_pkg; instantiated by glove_report_deframer_unit.
module glrd_frame_track
    import glrd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      step,
    input  glrd_in_t  item,
    input  glrd_cfg_t cfg,
    output glrd_evt_t evt
);

    typedef enum logic {
        HUNT   = 1'b0,
        GATHER = 1'b1
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [TIMER_WIDTH-1:0] idle_reg, idle_next;
    logic                   lock_reg, lock_next;

    logic [7:0]             store_reg [FRAME_MAX];
    logic                   store_we;
    logic [IDX_W-1:0]       store_idx;

    logic [COUNT_W-1:0]     len;
    logic [COUNT_W-1:0]     len_m1;
    logic [COUNT_W:0]       count_inc;
    logic [TIMER_WIDTH-1:0] ticks_sat;
    logic [7:0]             cap;
    logic                   cap_ok;

    always_comb begin
        if (32'(cfg.frame_length) < 32'(FRAME_MIN)) begin
            len = COUNT_W'(FRAME_MIN);
        end else if (32'(cfg.frame_length) > 32'(FRAME_MAX)) begin
            len = COUNT_W'(FRAME_MAX);
        end else begin
            len = COUNT_W'(cfg.frame_length);
        end
    end

    assign len_m1    = len - COUNT_W'(1);
    assign count_inc = {1'b0, count_reg} + {{COUNT_W{1'b0}}, 1'b1};
    assign ticks_sat = (&idle_reg) ? idle_reg : idle_reg + TIMER_WIDTH'(1);

    // The byte arriving now is the capability byte unless the length shrank
    // under a frame in progress.
    assign cap    = (count_reg == len_m1) ? item.rx_byte : store_reg[len_m1[IDX_W-1:0]];
    assign cap_ok = (cap == CAP_LEFT) || (cap == CAP_RIGHT);

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        idle_next  = idle_reg;
        lock_next  = lock_reg;
        store_we   = 1'b0;
        store_idx  = '0;
        evt        = '0;

        if (step) begin
            if (item.command == CMD_TICK) begin
                if (phase_reg == GATHER) begin
                    if (32'(ticks_sat) >= 32'(cfg.timeout_ticks)) begin
                        phase_next = HUNT;
                        count_next = '0;
                        idle_next  = '0;
                        lock_next  = 1'b0;
                        evt.valid  = 1'b1;
                        evt.kind   = EV_TIMEOUT;
                    end else begin
                        idle_next = ticks_sat;
                    end
                end
            end else begin
                idle_next = '0;
                if (phase_reg == HUNT) begin
                    if (item.rx_byte == HEADER_BYTE) begin
                        store_we   = 1'b1;
                        count_next = COUNT_W'(1);
                        phase_next = GATHER;
                    end
                end else begin
                    if (32'(count_reg) < 32'(FRAME_MAX)) begin
                        store_we  = 1'b1;
                        store_idx = count_reg[IDX_W-1:0];
                    end
                    if (count_inc < {1'b0, len}) begin
                        count_next = count_inc[COUNT_W-1:0];
                    end else if (store_reg[0] != HEADER_BYTE) begin
                        phase_next = HUNT;
                        count_next = '0;
                        lock_next  = 1'b0;
                        evt.valid  = 1'b1;
                        evt.kind   = EV_BAD_HEADER;
                    end else if (cfg.wireless_mode && !cap_ok) begin
                        phase_next = HUNT;
                        count_next = '0;
                        lock_next  = 1'b0;
                        evt.valid  = 1'b1;
                        evt.kind   = EV_BAD_CAP;
                    end else if (cfg.wireless_mode && !lock_reg) begin
                        // First good frame after a resync: confirm lock, report nothing.
                        lock_next  = 1'b1;
                        count_next = '0;
                    end else begin
                        count_next     = '0;
                        evt.valid      = 1'b1;
                        evt.kind       = EV_REPORT;
                        evt.right_hand = cfg.wireless_mode && (cap == CAP_RIGHT);
                        for (int k = 0; k < DATA_BYTES; k++) begin
                            evt.data_bytes[k] = store_reg[k + 1];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= HUNT;
            count_reg <= '0;
            idle_reg  <= '0;
            lock_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            idle_reg  <= idle_next;
            lock_reg  <= lock_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[store_idx] <= item.rx_byte;
        end
    end

endmodule

[sv/glrd_report_fmt.sv]
// Scales a decoded event into the result fields and holds the result beat.
// Depends on glrd_pkg; instantiated by glove_report_deframer_unit.
module glrd_report_fmt
    import glrd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  glrd_evt_t evt,
    output logic      m_valid,
    input  logic      m_ready,
    output glrd_out_t m_data
);

    logic      valid_reg, valid_next;
    glrd_out_t data_reg;
    glrd_out_t data_next;

    always_comb begin
        data_next.event_kind    = evt.kind;
        data_next.thumb         = finger_scale(evt.data_bytes[0]);
        data_next.index_finger  = finger_scale(evt.data_bytes[1]);
        data_next.middle_finger = finger_scale(evt.data_bytes[2]);
        data_next.ring_finger   = finger_scale(evt.data_bytes[3]);
        data_next.little_finger = finger_scale(evt.data_bytes[4]);
        data_next.pitch         = angle_scale(evt.data_bytes[5]);
        data_next.roll          = angle_scale(evt.data_bytes[6]);
        data_next.right_hand    = evt.right_hand;
    end

    // A load replaces the held beat; otherwise drop it once taken.
    always_comb begin
        if (load) begin
            valid_next = evt.valid;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && evt.valid) begin
            data_reg <= data_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

[sv/glove_report_deframer_unit.sv]
// Top level of the glove report deframer: input stage, configuration registers,
// frame tracker and result stage. Depends on glrd_pkg, glrd_frame_track, glrd_report_fmt.
//
//   port group | direction | payload      | handshake
//   s_*        | in        | glrd_in_t    | s_valid / s_ready
//   m_*        | out       | glrd_out_t   | m_valid / m_ready
//   cfg_*      | in        | cfg_wdata    | cfg_we, no wait
//
// One beat per cycle sustained while m_ready is high; an accepted beat passes from the
// input register through one pass of tracker and scaling into the result register.
// Synchronous active-low reset clears control state and loads register defaults;
// the byte store holds no reset value and every frame rewrites it before use.
// While m_ready is low the result beat is held; the input register then fills
// and s_ready drops until the result is taken.
module glove_report_deframer_unit
    import glrd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  glrd_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output glrd_out_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic      in_valid_reg, in_valid_next;
    glrd_in_t  in_data_reg;
    logic      advance;
    glrd_cfg_t cfg_reg;
    glrd_evt_t evt;

    // Advance the held beat whenever the result slot is free or being emptied.
    assign advance = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_length  <= FRAME_LENGTH_RST;
            cfg_reg.wireless_mode <= WIRELESS_MODE_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_LENGTH:  cfg_reg.frame_length  <= cfg_wdata[3:0];
                REG_WIRELESS_MODE: cfg_reg.wireless_mode <= cfg_wdata[0];
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    glrd_frame_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_data_reg),
        .cfg     (cfg_reg),
        .evt     (evt)
    );

    glrd_report_fmt u_fmt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .evt     (evt),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[sv/glrd_checker.sv]
// Port-level checks on the glove report deframer, bound to the top level.
// Depends on glrd_pkg and glove_report_deframer_unit.
module glrd_checker
    import glrd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  glrd_out_t             m_data
);

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Error and timeout beats carry no measurement.
    a_event_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_kind != EV_REPORT) |->
            m_data.thumb == 16'd0 && m_data.index_finger == 16'd0 &&
            m_data.middle_finger == 16'd0 && m_data.ring_finger == 16'd0 &&
            m_data.little_finger == 16'd0 && m_data.pitch == 16'd0 &&
            m_data.roll == 16'd0 && !m_data.right_hand)
        else $error("non-report beat with payload");

    // Reports keep angles within half a turn, thumb and little finger on the byte*257 grid.
    a_report_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.event_kind == EV_REPORT) |->
            m_data.pitch <= 16'd46080 && m_data.roll <= 16'd46080 &&
            m_data.thumb[15:8] == m_data.thumb[7:0] &&
            m_data.little_finger[15:8] == m_data.little_finger[7:0])
        else $error("report fields out of range");

    // Nothing comes out in the cycle after reset.
    a_reset_idle: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

endmodule

bind glove_report_deframer_unit glrd_checker u_glrd_checker (.*);
